[rtl/assert_macros.svh]
// Assertion macros shared by the escape-time RTL.
// Each macro expects clk and rst to be visible where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every clock edge out of reset
`define MBE_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// consequence in the cycle after the antecedent
`define MBE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/mbe_pkg.sv]
// Constants, state codes and control structs for the escape-time block.
// No dependencies; used by the interfaces, controller, datapath and top level.
package mbe_pkg;

  localparam int DATA_WIDTH  = 32;
  localparam int FRAC_BITS   = 28;
  localparam int COUNT_WIDTH = 13;
  localparam int ITER_WIDTH  = 12;
  localparam int PROD_W      = 2 * DATA_WIDTH;
  localparam int SUM_W       = PROD_W + 2;

  localparam logic [ITER_WIDTH-1:0] ITER_RESET = ITER_WIDTH'(1024);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_MUL  = 5'b00010,
    S_ADD  = 5'b00100,
    S_UPD  = 5'b01000,
    S_EMIT = 5'b10000
  } state_t;

  typedef struct packed {
    logic load;
    logic mul_en;
    logic add_en;
    logic upd_en;
    logic emit;
  } dp_cmd_t;

  typedef struct packed {
    logic stop;
  } dp_status_t;

endpackage

[rtl/mbe_if.sv]
// Valid/ready channel interfaces: point input, result output, limit write.
// Depends on mbe_pkg for field widths.
interface mbe_pt_if;
  logic                                valid;
  logic                                ready;
  logic signed [mbe_pkg::DATA_WIDTH-1:0] c_real;
  logic signed [mbe_pkg::DATA_WIDTH-1:0] c_imag;
  modport source (output valid, c_real, c_imag, input ready);
  modport sink (input valid, c_real, c_imag, output ready);
endinterface

interface mbe_res_if;
  logic                             valid;
  logic                             ready;
  logic [mbe_pkg::COUNT_WIDTH-1:0]  iteration_count;
  logic                             escaped;
  modport source (output valid, iteration_count, escaped, input ready);
  modport sink (input valid, iteration_count, escaped, output ready);
endinterface

interface mbe_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [mbe_pkg::ITER_WIDTH-1:0]  data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

[rtl/mbe_ctrl.sv]
// Sequencer for the escape-time loop: multiply, sum/compare, update, emit.
// Depends on mbe_pkg and assert_macros.svh.
`include "assert_macros.svh"

module mbe_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  output mbe_pkg::dp_cmd_t    cmd,
  input  mbe_pkg::dp_status_t status
);
  import mbe_pkg::*;

  state_t state, state_next;
  logic   out_free;
  logic   in_accept;

  assign in_ready  = (state == S_IDLE);
  assign in_accept = in_valid && in_ready;
  assign out_free  = !out_valid || out_ready;

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul_en = 1'b1;
        state_next = S_ADD;
      end
      S_ADD: begin
        cmd.add_en = 1'b1;
        state_next = S_UPD;
      end
      S_UPD: begin
        if (status.stop) begin
          state_next = S_EMIT;
        end else begin
          cmd.upd_en = 1'b1;
          state_next = S_MUL;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  `MBE_ASSERT_NEXT(a_accept_starts, in_accept, state == S_MUL, "accept did not start loop")
  `MBE_ASSERT_NEXT(a_emit_valid, cmd.emit, out_valid, "emit did not raise result valid")
  `MBE_ASSERT(a_emit_free, !cmd.emit || out_free, "emit over an untaken result")

endmodule

[rtl/mbe_dpath.sv]
// Datapath: z registers, three shared multipliers, magnitude test, update.
// Depends on mbe_pkg and assert_macros.svh.
`include "assert_macros.svh"

module mbe_dpath (
  input  logic                                 clk,
  input  logic                                 rst,
  input  mbe_pkg::dp_cmd_t                     cmd,
  output mbe_pkg::dp_status_t                  status,
  input  logic signed [mbe_pkg::DATA_WIDTH-1:0] c_real,
  input  logic signed [mbe_pkg::DATA_WIDTH-1:0] c_imag,
  input  logic [mbe_pkg::ITER_WIDTH-1:0]       max_iterations,
  output logic [mbe_pkg::COUNT_WIDTH-1:0]      iteration_count,
  output logic                                 escaped
);
  import mbe_pkg::*;

  localparam logic [PROD_W:0] FOUR = (PROD_W + 1)'(1) << (2 * FRAC_BITS + 2);
  localparam logic signed [DATA_WIDTH-1:0] DMAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam logic signed [DATA_WIDTH-1:0] DMIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

  logic signed [DATA_WIDTH-1:0]  zr, zi, cr, ci;
  logic signed [PROD_W-1:0]      rr, ii, ri;
  logic signed [PROD_W:0]        diff;
  logic [COUNT_WIDTH-1:0]        count;
  logic                          stop;
  logic [PROD_W:0]               mag;
  logic signed [PROD_W:0]        diff_sh;
  logic signed [PROD_W-1:0]      ri_sh;
  logic signed [SUM_W-1:0]       re_sum, im_sum;
  logic [COUNT_WIDTH-1:0]        max_ext;

  function automatic logic signed [DATA_WIDTH-1:0] sat_data(
    input logic signed [SUM_W-1:0] v
  );
    logic fits;
    fits = (v[SUM_W-1:DATA_WIDTH-1] == '0) || (v[SUM_W-1:DATA_WIDTH-1] == '1);
    if (fits) begin
      return v[DATA_WIDTH-1:0];
    end else if (v[SUM_W-1]) begin
      return DMIN;
    end else begin
      return DMAX;
    end
  endfunction

  assign max_ext = COUNT_WIDTH'(max_iterations);
  assign mag     = (PROD_W + 1)'(unsigned'(rr)) + (PROD_W + 1)'(unsigned'(ii));
  assign diff_sh = diff >>> FRAC_BITS;
  assign ri_sh   = ri >>> (FRAC_BITS - 1);
  assign re_sum  = SUM_W'(diff_sh) + SUM_W'(cr);
  assign im_sum  = SUM_W'(ri_sh) + SUM_W'(ci);
  assign status.stop = stop;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      zr    <= '0;
      zi    <= '0;
      cr    <= c_real;
      ci    <= c_imag;
      count <= '0;
    end
    if (cmd.mul_en) begin
      rr <= zr * zr;
      ii <= zi * zi;
      ri <= zr * zi;
    end
    if (cmd.add_en) begin
      diff <= (PROD_W + 1)'(rr) - (PROD_W + 1)'(ii);
      stop <= (mag >= FOUR) || (count > max_ext);
    end
    if (cmd.upd_en) begin
      zr    <= sat_data(re_sum);
      zi    <= sat_data(im_sum);
      count <= count + 1'b1;
    end
    if (cmd.emit) begin
      iteration_count <= count;
      escaped         <= (count < max_ext);
    end
  end

  `MBE_ASSERT(a_count_bound, !cmd.emit || (count <= max_ext + 1'b1), "count past limit")
  `MBE_ASSERT_NEXT(a_count_step, cmd.upd_en, count == $past(count) + 1'b1, "count not stepped")
  `MBE_ASSERT(a_upd_live, !(cmd.upd_en && stop), "update after stop")

endmodule

[rtl/mandelbrot_escape_time.sv]
// Top level of the escape-time block: limit register, controller, datapath.
// Depends on mbe_pkg, mbe_if, mbe_ctrl and mbe_dpath.
//
// Takes one point c per beat and returns its escape count and escaped flag.
// One iteration of z = z*z + c steps through three states (multiply,
// magnitude sum and compare, update), using one set of three 32x32
// multipliers. A point runs at most max_iterations + 1 iterations;
// the next point is accepted in the cycle after its result is handed to
// the output register, even if the result is not yet taken.
// max_iterations resets to 1024; the user must write it only while no
// point is in flight, and the block itself does not enforce this.
module mandelbrot_escape_time (
  input logic         clk,
  input logic         rst,
  mbe_cfg_if.sink     cfg,
  mbe_pt_if.sink      point,
  mbe_res_if.source   result
);
  import mbe_pkg::*;

  logic [ITER_WIDTH-1:0] max_iterations;
  dp_cmd_t               cmd;
  dp_status_t            status;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_iterations <= ITER_RESET;
    end else if (cfg.valid && cfg.ready) begin
      max_iterations <= cfg.data;
    end
  end

  mbe_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (point.valid),
    .in_ready  (point.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .cmd       (cmd),
    .status    (status)
  );

  mbe_dpath u_dpath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .status          (status),
    .c_real          (point.c_real),
    .c_imag          (point.c_imag),
    .max_iterations  (max_iterations),
    .iteration_count (result.iteration_count),
    .escaped         (result.escaped)
  );

endmodule

[bench/tb_top.sv]
// Self-checking bench for mandelbrot_escape_time: random valid/ready gaps on both sides.
// Escape counts are predicted in fixed point inside a small scoreboard class.
// Depends on mbe_pkg, the mbe_if interfaces and the RTL top level.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import mbe_pkg::*;

  localparam int CYCLE_LIMIT   = 3_000_000;
  localparam int RANDOM_POINTS = 560;
  localparam int DRAIN_CYCLES  = 64;

  typedef logic signed [DATA_WIDTH-1:0] part_t;
  typedef logic signed [SUM_W-1:0]      wide_t;

  typedef struct packed {
    logic [COUNT_WIDTH-1:0] iteration_count;
    logic                   escaped;
  } escape_t;

  localparam part_t PART_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam part_t PART_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

  class escape_scoreboard;
    logic [ITER_WIDTH-1:0] iter_limit;
    escape_t               pending_escapes[$];
    int unsigned           failures;

    function new();
      iter_limit = ITER_RESET;
      failures   = 0;
    endfunction

    function void set_limit(logic [ITER_WIDTH-1:0] value);
      iter_limit = value;
    endfunction

    function wide_t clamp_part(wide_t v);
      wide_t hi;
      wide_t lo;
      hi = {{(SUM_W-DATA_WIDTH+1){1'b0}}, {(DATA_WIDTH-1){1'b1}}};
      lo = -hi - 1;
      if (v > hi) return hi;
      if (v < lo) return lo;
      return v;
    endfunction

    function escape_t predict_escape(part_t cr, part_t ci);
      wide_t       zr, zi, cr_w, ci_w, rr, ii, ri, four;
      int unsigned count;
      escape_t     res;
      cr_w  = wide_t'(cr);
      ci_w  = wide_t'(ci);
      zr    = '0;
      zi    = '0;
      four  = wide_t'(1);
      four  = four <<< (2 * FRAC_BITS + 2);
      count = 0;
      forever begin
        rr = zr * zr;
        ii = zi * zi;
        if (rr + ii >= four || count > iter_limit) break;
        ri = zr * zi;
        zr = clamp_part(((rr - ii) >>> FRAC_BITS) + cr_w);
        zi = clamp_part((ri >>> (FRAC_BITS - 1)) + ci_w);
        count++;
      end
      res.iteration_count = COUNT_WIDTH'(count);
      res.escaped         = (count < iter_limit);
      return res;
    endfunction

    function void note_point(part_t cr, part_t ci);
      pending_escapes.push_back(predict_escape(cr, ci));
    endfunction

    function void check_result(logic [COUNT_WIDTH-1:0] count, logic escaped);
      escape_t want;
      if (pending_escapes.size() == 0) begin
        $error("unexpected result: iteration_count %0d escaped %0d", count, escaped);
        failures++;
        return;
      end
      want = pending_escapes.pop_front();
      if (want.iteration_count !== count) begin
        $error("iteration_count: expected %0d, actual %0d", want.iteration_count, count);
        failures++;
      end
      if (want.escaped !== escaped) begin
        $error("escaped: expected %0d, actual %0d", want.escaped, escaped);
        failures++;
      end
    endfunction
  endclass

  logic             clk = 1'b0;
  logic             rst;
  int unsigned      cycle_count = 0;
  bit               tx_burst;
  bit               rx_burst;
  escape_scoreboard sb;

  mbe_cfg_if cfg_ch ();
  mbe_pt_if  point_ch ();
  mbe_res_if result_ch ();

  mandelbrot_escape_time i_dut (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg_ch),
    .point  (point_ch),
    .result (result_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  function automatic part_t to_q(real r);
    return part_t'($rtoi(r * (2.0 ** FRAC_BITS)));
  endfunction

  task automatic write_limit(logic [ITER_WIDTH-1:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    sb.set_limit(value);
  endtask

  task automatic send_point(part_t cr, part_t ci);
    int unsigned gap;
    gap = tx_burst ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      point_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    point_ch.valid  <= 1'b1;
    point_ch.c_real <= cr;
    point_ch.c_imag <= ci;
    do @(posedge clk); while (!point_ch.ready);
    sb.note_point(cr, ci);
  endtask

  task automatic drain_results();
    int unsigned gap;
    gap = rx_burst ? 0 : $urandom_range(0, 17);
    forever begin
      if (gap > 0) begin
        result_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      result_ch.ready <= 1'b1;
      do @(posedge clk); while (!result_ch.valid);
      sb.check_result(result_ch.iteration_count, result_ch.escaped);
      gap = rx_burst ? 0 : $urandom_range(0, 17);
    end
  endtask

  // drop valid and hold until every beat in flight has come back
  task automatic settle();
    point_ch.valid <= 1'b0;
    while (sb.pending_escapes.size() != 0) @(posedge clk);
  endtask

  initial begin
    int unsigned           sent;
    int unsigned           phase_len;
    part_t                 cr;
    part_t                 ci;
    logic [ITER_WIDTH-1:0] lim;
    sb = new();
    tx_burst = 1'b0;
    rx_burst = 1'b0;
    rst             <= 1'b1;
    cfg_ch.valid    <= 1'b0;
    cfg_ch.data     <= '0;
    point_ch.valid  <= 1'b0;
    point_ch.c_real <= '0;
    point_ch.c_imag <= '0;
    result_ch.ready <= 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    fork
      drain_results();
    join_none

    send_point(to_q(0.0), to_q(0.0));
    send_point(to_q(-1.0), to_q(0.0));
    send_point(to_q(-2.0), to_q(0.0));
    send_point(to_q(0.25), to_q(0.0));
    send_point(to_q(0.26), to_q(0.0));
    send_point(to_q(-0.75), to_q(0.1));
    send_point(to_q(0.0), to_q(1.0));
    send_point(to_q(0.0), to_q(-1.0));
    send_point(to_q(-0.1), to_q(0.651));
    send_point(part_t'(32'sh1FFF_FFFF), to_q(0.0));
    send_point(PART_MAX, PART_MAX);
    send_point(PART_MIN, PART_MIN);
    send_point(PART_MAX, PART_MIN);
    send_point(PART_MIN, PART_MAX);
    settle();

    write_limit(12'd4095);
    send_point(to_q(0.0), to_q(0.0));
    send_point(to_q(-1.0), to_q(0.0));
    send_point(to_q(0.26), to_q(0.0));
    settle();

    write_limit(12'd0);
    send_point(to_q(0.0), to_q(0.0));
    send_point(PART_MIN, PART_MAX);
    send_point(to_q(-1.0), to_q(0.0));
    settle();

    write_limit(12'd1);
    send_point(to_q(0.0), to_q(0.0));
    send_point(to_q(-2.0), to_q(0.0));
    settle();

    sent = 0;
    while (sent < RANDOM_POINTS) begin
      case ($urandom_range(0, 9))
        0:       lim = ITER_WIDTH'($urandom_range(41, 255));
        1:       lim = ITER_WIDTH'($urandom_range(1, 3));
        default: lim = ITER_WIDTH'($urandom_range(1, 40));
      endcase
      tx_burst = ($urandom_range(0, 3) == 0);
      rx_burst = ($urandom_range(0, 3) == 0);
      write_limit(lim);
      phase_len = $urandom_range(20, 60);
      repeat (phase_len) begin
        case ($urandom_range(0, 9))
          7, 8: begin
            cr = $urandom;
            ci = $urandom;
          end
          9: begin
            cr = $urandom;
            ci = part_t'($urandom) >>> $urandom_range(0, 31);
          end
          default: begin
            cr = part_t'(int'($urandom_range(0, 32'h2800_0000)) - (1 <<< 29));
            ci = part_t'(int'($urandom_range(0, 32'h2800_0000)) - 32'sh1400_0000);
          end
        endcase
        send_point(cr, ci);
        sent++;
      end
      settle();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.failures == 0 && sb.pending_escapes.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
